// File: rtl/core/lsfe_pkg.sv
`default_nettype none
package lsfe_pkg;
   localparam int MaxNodes   = 64;
   localparam int NodeBits   = 6;
   localparam int WeightBits = 16;
   localparam int EnergyBits = 40;
   localparam int RowBits    = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_EVAL  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_ROW_RD,
      ST_ROW_ACC,
      ST_ROW_END,
      ST_OUT_RD,
      ST_OUT_CALC,
      ST_OUT_EMIT
   } state_type;
endpackage
`default_nettype wire

// File: rtl/core/laplacian_single_flip_energies_unit.sv
// Single-flip energy scorer.
// Input: start/busy command port. A transaction is taken when start is high and
// busy is low; req_cmd picks clear, add edge or evaluate (code 3 is ignored).
// Config: csr_valid/csr_ready write node_count; ready is high only while idle.
// Clear sweeps the whole weight store one entry per cycle and zeroes the degree
// counts on the way.
// Add edge: reads the degrees, then writes the weights and degrees.
// Evaluate: first pass reads every weight of the active n x n square through the
// single weight memory port, one entry a cycle, plus a read step and an end step
// per row; then results come one at a time (read row sum, compute, emit).
// Results come out on rsp_* with rsp_valid high for one cycle each, index order,
// rsp_last on the last; the receiver cannot stall them.
// Reset: synchronous, clears the store by running the clear sweep (busy high) and
// sets node_count to 64.
`default_nettype none
module laplacian_single_flip_energies_unit
   import lsfe_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [NodeBits-1:0]          req_node_a,
   input  wire logic [NodeBits-1:0]          req_node_b,
   input  wire logic signed [WeightBits-1:0] req_edge_weight,
   input  wire logic [MaxNodes-1:0]          req_state_vector,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [6:0]                   csr_node_count,
   output logic                              rsp_valid,
   output logic [NodeBits-1:0]               rsp_flip_index,
   output logic signed [EnergyBits-1:0]      rsp_energy,
   output logic                              rsp_last
);
   localparam int AddrBits = 2*NodeBits;

   // memories
   logic signed [WeightBits-1:0] wmem [MaxNodes*MaxNodes];
   logic [15:0]                  dmem [MaxNodes];
   logic signed [RowBits-1:0]    rmem [MaxNodes];

   state_type state_ff, state_in;
   logic [6:0] node_count_ff;
   logic [6:0] n_ff;
   logic [NodeBits-1:0] a_ff, b_ff;
   logic signed [WeightBits-1:0] w_ff;
   logic [MaxNodes-1:0] y_ff;
   logic [6:0] i_ff, j_ff;
   logic [1:0] ph_ff;
   logic signed [RowBits-1:0] acc_ff;
   logic signed [47:0] base_ff;
   logic signed [47:0] e_ff;
   logic [NodeBits-1:0] fi_ff;
   logic lst_ff;

   logic signed [WeightBits-1:0] wrd_ff;
   logic [15:0] da_ff, db_ff, dd_ff;
   logic signed [RowBits-1:0] rrd_ff;
   logic ybit_ff;

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   logic [6:0] n_eff;
   assign n_eff = (node_count_ff > 7'(MaxNodes)) ? 7'(MaxNodes) : node_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_EDGE: begin
                     if ({1'b0, req_node_a} < n_eff && {1'b0, req_node_b} < n_eff)
                        state_in = ST_EDGE_RD;
                  end
                  CMD_EVAL: if (n_eff != 7'd0) state_in = ST_ROW_RD;
                  CMD_NONE: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (i_ff == 7'(MaxNodes-1) && j_ff == 7'(MaxNodes-1)) state_in = ST_IDLE;
         end
         ST_EDGE_RD:  if (ph_ff == 2'd1) state_in = ST_EDGE_WR;
         ST_EDGE_WR:  if (ph_ff == 2'd1) state_in = ST_IDLE;
         ST_ROW_RD:   state_in = ST_ROW_ACC;
         ST_ROW_ACC:  if (j_ff == n_ff) state_in = ST_ROW_END;
         ST_ROW_END:  state_in = (i_ff + 7'd1 == n_ff) ? ST_OUT_RD : ST_ROW_RD;
         ST_OUT_RD:   state_in = ST_OUT_CALC;
         ST_OUT_CALC: state_in = ST_OUT_EMIT;
         ST_OUT_EMIT: state_in = (i_ff + 7'd1 == n_ff) ? ST_IDLE : ST_OUT_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_valid      = (state_ff == ST_OUT_EMIT);
      rsp_flip_index = fi_ff;
      rsp_last       = lst_ff;
      rsp_energy     = e_ff[EnergyBits-1:0];
   end

   // weight address: i*64 + j, shared by the clear sweep and the row pass
   logic [AddrBits-1:0] waddr;
   assign waddr = {i_ff[NodeBits-1:0], j_ff[NodeBits-1:0]};

   // weight memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         wmem[waddr] <= '0;
      end else if (state_ff == ST_EDGE_WR && ph_ff == 2'd0) begin
         wmem[{a_ff, b_ff}] <= w_ff;
      end else if (state_ff == ST_EDGE_WR && ph_ff == 2'd1) begin
         wmem[{b_ff, a_ff}] <= w_ff;
      end
      wrd_ff <= wmem[waddr];
   end

   // degree memory
   logic [16:0] dsum_a, dsum_b;
   logic [15:0] dnew_a, dnew_b;
   always_comb begin
      dsum_a = {1'b0, da_ff} + ((a_ff == b_ff) ? 17'd2 : 17'd1);
      dsum_b = {1'b0, db_ff} + 17'd1;
      dnew_a = dsum_a[16] ? 16'hFFFF : dsum_a[15:0];
      dnew_b = dsum_b[16] ? 16'hFFFF : dsum_b[15:0];
   end

   logic [NodeBits-1:0] drd_addr;
   always_comb begin
      drd_addr = i_ff[NodeBits-1:0];
      if (state_ff == ST_EDGE_RD) drd_addr = (ph_ff == 2'd0) ? a_ff : b_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR && j_ff == 7'd0)
         dmem[i_ff[NodeBits-1:0]] <= '0;
      else if (state_ff == ST_EDGE_WR && ph_ff == 2'd0)
         dmem[a_ff] <= dnew_a;
      else if (state_ff == ST_EDGE_WR && ph_ff == 2'd1 && a_ff != b_ff)
         dmem[b_ff] <= dnew_b;
      dd_ff <= dmem[drd_addr];
   end

   // row-sum memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROW_END)
         rmem[i_ff[NodeBits-1:0]] <= acc_ff;
      rrd_ff <= rmem[i_ff[NodeBits-1:0]];
   end

   // datapath: accumulation uses data read in the previous cycle for column j-1
   logic [6:0] jprev;
   logic signed [RowBits-1:0] term;
   assign jprev = j_ff - 7'd1;
   always_comb begin
      term = '0;
      if (y_ff[jprev[NodeBits-1:0]]) begin
         if (jprev == i_ff) term = RowBits'($signed({1'b0, dd_ff, 8'd0}));
         else               term = -RowBits'(wrd_ff);
      end
   end

   logic signed [47:0] ecalc;
   logic signed [47:0] diag;
   always_comb begin
      diag  = 48'($signed({1'b0, dd_ff, 8'd0}));
      ecalc = ybit_ff ? (base_ff - 48'(rrd_ff) * 2 + diag)
                      : (base_ff + 48'(rrd_ff) * 2 + diag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= 7'd64;
         i_ff          <= '0;
         j_ff          <= '0;
         ph_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) node_count_ff <= csr_node_count;
         unique case (state_ff)
            ST_IDLE: begin
               i_ff  <= '0;
               j_ff  <= '0;
               ph_ff <= '0;
            end
            ST_CLEAR: begin
               if (j_ff == 7'(MaxNodes-1)) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 7'd1;
               end else begin
                  j_ff <= j_ff + 7'd1;
               end
            end
            ST_EDGE_RD: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff == 2'd1) ph_ff <= '0;
            end
            ST_EDGE_WR: ph_ff <= ph_ff + 2'd1;
            ST_ROW_RD:  j_ff <= 7'd1;
            ST_ROW_ACC: j_ff <= j_ff + 7'd1;
            ST_ROW_END: begin
               j_ff <= '0;
               i_ff <= (i_ff + 7'd1 == n_ff) ? 7'd0 : i_ff + 7'd1;
            end
            ST_OUT_EMIT: i_ff <= i_ff + 7'd1;
            default: ;
         endcase
      end
   end

   // degree latches during edge add
   always_ff @(posedge clock) begin
      if (state_ff == ST_EDGE_RD && ph_ff == 2'd1) da_ff <= dd_ff;
      if (state_ff == ST_EDGE_WR && ph_ff == 2'd0) db_ff <= dd_ff;
   end

   // payload
   logic signed [47:0] sat_e;
   always_comb begin
      if (ecalc > 48'sd549755813887)        sat_e = 48'sd549755813887;
      else if (ecalc < -48'sd549755813888)  sat_e = -48'sd549755813888;
      else                                  sat_e = ecalc;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff   <= req_node_a;
         b_ff   <= req_node_b;
         w_ff   <= req_edge_weight;
         y_ff   <= req_state_vector;
         n_ff   <= n_eff;
      end
      if (state_ff == ST_IDLE) base_ff <= '0;
      if (state_ff == ST_ROW_RD) acc_ff <= '0;
      if (state_ff == ST_ROW_ACC) acc_ff <= acc_ff + term;
      if (state_ff == ST_ROW_END && y_ff[i_ff[NodeBits-1:0]])
         base_ff <= base_ff + 48'(acc_ff);
      if (state_ff == ST_OUT_RD) ybit_ff <= y_ff[i_ff[NodeBits-1:0]];
      if (state_ff == ST_OUT_CALC) begin
         e_ff  <= sat_e;
         fi_ff <= i_ff[NodeBits-1:0];
         lst_ff <= (i_ff + 7'd1 == n_ff);
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/lsfe_checker.sv
`default_nettype none
module lsfe_checker
   import lsfe_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic csr_ready,
   input wire logic rsp_valid,
   input wire logic rsp_last
);
   a_ready: assert property (@(posedge clock) disable iff (reset) csr_ready == !busy)
      else $error("csr_ready not idle");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result while idle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy) else $error("busy after last");
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results adjacent");
endmodule

bind laplacian_single_flip_energies_unit lsfe_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy),
   .csr_ready(csr_ready), .rsp_valid(rsp_valid), .rsp_last(rsp_last)
);
`default_nettype wire
